// ===== design/pgdb_pkg.sv =====
// Package: shared types, constants and arithmetic helpers for the Prewitt gradient block.
package pgdb_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W    = OUT_PTR_W + 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic signed [11:0]  MIN_START    = 12'sd1530;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // window element at row * 3 + column, row 0 above, column 0 left
  typedef logic [8:0][7:0] win_t;

  typedef struct packed {
    logic signed [10:0] row_gradient;
    logic signed [10:0] column_gradient;
    logic signed [11:0] gradient_sum;
    logic [3:0]         direction_bin;
    logic               frame_last;
    logic signed [11:0] frame_min;
    logic [10:0]        frame_max;
  } res_t;

  // sin and cos of 20, 40, ..., 160 degrees in Q31
  localparam logic signed [31:0] SIN_Q31 [8] = '{
    32'sd734482665,  32'sd1380375881, 32'sd1859775393, 32'sd2114858546,
    32'sd2114858546, 32'sd1859775393, 32'sd1380375881, 32'sd734482665
  };
  localparam logic signed [31:0] COS_Q31 [8] = '{
    32'sd2017974537,  32'sd1645067915,  32'sd1073741824,  32'sd372906622,
    -32'sd372906622,  -32'sd1073741824, -32'sd1645067915, -32'sd2017974537
  };

  // floor(s / 3) for s up to 765 by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] s);
    logic [19:0] p;
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

  function automatic win_t win_shift(input win_t w, input logic [7:0] up,
                                     input logic [7:0] mid, input logic [7:0] low);
    win_t o;
    o    = w;
    o[0] = w[1]; o[1] = w[2]; o[2] = up;
    o[3] = w[4]; o[4] = w[5]; o[5] = mid;
    o[6] = w[7]; o[7] = w[8]; o[8] = low;
    return o;
  endfunction

  function automatic logic signed [10:0] row_grad(input win_t w);
    logic [9:0] lo_sum;
    logic [9:0] hi_sum;
    lo_sum = 10'(w[6]) + 10'(w[7]) + 10'(w[8]);
    hi_sum = 10'(w[0]) + 10'(w[1]) + 10'(w[2]);
    return $signed({1'b0, lo_sum}) - $signed({1'b0, hi_sum});
  endfunction

  function automatic logic signed [10:0] col_grad(input win_t w);
    logic [9:0] rt_sum;
    logic [9:0] lf_sum;
    rt_sum = 10'(w[2]) + 10'(w[5]) + 10'(w[8]);
    lf_sum = 10'(w[0]) + 10'(w[3]) + 10'(w[6]);
    return $signed({1'b0, rt_sum}) - $signed({1'b0, lf_sum});
  endfunction

  // folded atan2 bin: count boundaries at 20..160 degrees at or below the angle
  function automatic logic [3:0] dir_bin(input logic signed [10:0] rg,
                                         input logic signed [10:0] cg);
    logic signed [11:0] w;
    logic signed [11:0] h;
    logic signed [44:0] ps;
    logic signed [44:0] pc;
    logic [3:0]         bin;
    w   = 12'(rg);
    h   = 12'(cg);
    bin = 4'd0;
    if (h < 0) begin
      h = -h;
      w = -w;
    end
    if (h == 0) begin
      bin = (w < 0) ? 4'd8 : 4'd0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        ps = 45'(w) * 45'(SIN_Q31[k]);
        pc = 45'(h) * 45'(COS_Q31[k]);
        if (ps - pc <= 0) bin = bin + 4'd1;
      end
    end
    return bin;
  endfunction

endpackage

// ===== design/pgdb_if.sv =====
// Interfaces: pixel input channel and gradient result channel.
interface pgdb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       is_filler;

  modport source (output valid, blue, green, red, is_filler, input ready);
  modport sink   (input valid, blue, green, red, is_filler, output ready);
endinterface

interface pgdb_res_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] row_gradient;
  logic signed [10:0] column_gradient;
  logic signed [11:0] gradient_sum;
  logic [3:0]         direction_bin;
  logic               frame_last;
  logic signed [11:0] frame_min;
  logic [10:0]        frame_max;

  modport source (output valid, row_gradient, column_gradient, gradient_sum,
                  direction_bin, frame_last, frame_min, frame_max, input ready);
  modport sink   (input valid, row_gradient, column_gradient, gradient_sum,
                  direction_bin, frame_last, frame_min, frame_max, output ready);
endinterface

// ===== design/prewitt_gradient_direction_bins.sv =====
// Top level: Prewitt 3x3 gradients, direction bins and running min/max on a raster pixel stream.
// One RGB pixel beat is taken per clock while ready is high; each becomes gray (b+g+r)/3 through
// a reciprocal multiply. The pixel and its address enter a front register together with a read
// of the line store (one 1024 x 16 memory holding the two previous rows, one read and one write a
// cycle). The window stage then shifts the 3x3 window, forms both gradients, their sum and the
// running min/max; the bin stage adds the direction bin and pushes the results into an 8-deep
// output queue. A pixel yields one result (none on the first row and first column); the last
// pixel of a row yields two, so a row gives as many results as pixels and the output port,
// draining one beat a clock, keeps pace: ready stays high every cycle unless the result side
// stalls and the queue backs up. Sustained rate is one pixel per clock with no stall cycles when
// the result side never stalls. After the frame, feed one row of flush beats (any data) to
// release the last row; the last of them carries frame_last. A filler beat inside the frame is
// taken and dropped. Writing frame_width or frame_height (only while idle) clamps the value and
// restarts the frame.
module prewitt_gradient_direction_bins (
  input  logic                          clk,
  input  logic                          rst_n,
  pgdb_pix_if.sink                      in_pix,
  pgdb_res_if.source                    out_res,
  input  logic                          cfg_we,
  input  logic [pgdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgdb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pgdb_pkg::*;

  // configuration
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [WIDTH_W-1:0]  width_clamp;
  logic [HEIGHT_W-1:0] height_clamp;
  logic                cfg_restart;

  // front stage: raster position
  logic [COL_W-1:0]    col_r;
  logic [HEIGHT_W-1:0] row_r;
  logic                in_acc;
  logic                take;
  logic                flushing;
  logic                last_col;
  logic [7:0]          gray;

  // line store: {upper, lower}
  logic [15:0]         line_mem [MAX_WIDTH];
  logic [15:0]         rd_r;

  // window stage
  logic                s1_v_r;
  logic [COL_W-1:0]    s1_addr_r;
  logic                s1_col0_r;
  logic                s1_row_nz_r;
  logic                s1_emit1_r;
  logic                s1_emit2_r;
  logic                s1_last_r;
  logic [7:0]          s1_gray_r;
  logic [7:0]          up_px;
  logic [7:0]          mid_px;
  win_t                win_r;
  win_t                win_base;
  win_t                win_a;
  win_t                win_b;
  logic signed [10:0]  rg_a, cg_a, rg_b, cg_b;
  logic signed [11:0]  sum_a, sum_b;
  logic signed [11:0]  min_r, min_a, min_b;
  logic [10:0]         max_r, max_a, max_b;
  logic [1:0]          s1_n;

  // bin stage
  logic                s2_v1_r;
  logic                s2_v2_r;
  res_t                s2_res1_r;
  res_t                s2_res2_r;
  res_t                res1;
  res_t                res2;
  logic [1:0]          s2_n;

  // output queue
  res_t                q_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wp_r;
  logic [OUT_PTR_W-1:0] rp_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic [OUT_CNT_W:0]   pending;
  logic                 pop;
  res_t                 head;

  // clamp register writes
  always_comb begin
    width_clamp = cfg_wdata[WIDTH_W-1:0];
    if (width_clamp < WIDTH_W'(2)) width_clamp = WIDTH_W'(2);
    if (width_clamp > WIDTH_W'(MAX_WIDTH)) width_clamp = WIDTH_W'(MAX_WIDTH);
    height_clamp = cfg_wdata[HEIGHT_W-1:0];
    if (height_clamp < HEIGHT_W'(2)) height_clamp = HEIGHT_W'(2);
    if (height_clamp > HEIGHT_W'(HEIGHT_LIMIT)) height_clamp = HEIGHT_W'(HEIGHT_LIMIT);
  end

  assign cfg_restart = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                                  cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= width_clamp;
        REG_FRAME_HEIGHT: height_r <= height_clamp;
        default: ;
      endcase
    end
  end

  // Hold ready low unless the queue can absorb everything in flight plus two more.
  assign pending      = (OUT_CNT_W+1)'(cnt_r) + (OUT_CNT_W+1)'(s1_n) + (OUT_CNT_W+1)'(s2_n);
  assign in_pix.ready = pending <= (OUT_CNT_W+1)'(OUT_DEPTH - 2);
  assign in_acc       = in_pix.valid && in_pix.ready;

  // Rows past the frame height are the flush row: data is ignored, gray is zero.
  assign flushing = row_r >= height_r;
  assign take     = in_acc && (flushing || !in_pix.is_filler);
  assign last_col = (WIDTH_W'(col_r) + WIDTH_W'(1)) >= width_r;
  assign gray     = flushing ? 8'd0
                             : div3(10'(in_pix.blue) + 10'(in_pix.green) + 10'(in_pix.red));

  // Advance the raster position; wrap to the next frame after the flush row.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= flushing ? '0 : row_r + HEIGHT_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r   <= col_r;
      s1_col0_r   <= col_r == '0;
      s1_row_nz_r <= row_r != '0;
      s1_emit1_r  <= (row_r != '0) && (col_r != '0);
      s1_emit2_r  <= last_col && (row_r != '0);
      s1_last_r   <= flushing;
      s1_gray_r   <= gray;
    end
  end

  // Read the column at accept; write back {old lower, new gray} in the following cycle.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_r <= line_mem[col_r];
    end
    if (s1_v_r) begin
      line_mem[s1_addr_r] <= {mid_px, s1_gray_r};
    end
  end

  // Window: zero padding on row 0 and at the start of a row; an extra zero column
  // after the last pixel of a row gives the right-edge center.
  assign up_px    = s1_row_nz_r ? rd_r[15:8] : 8'd0;
  assign mid_px   = s1_row_nz_r ? rd_r[7:0]  : 8'd0;
  assign win_base = s1_col0_r ? '0 : win_r;
  assign win_a    = win_shift(win_base, up_px, mid_px, s1_gray_r);
  assign win_b    = win_shift(win_a, 8'd0, 8'd0, 8'd0);
  assign rg_a     = row_grad(win_a);
  assign cg_a     = col_grad(win_a);
  assign rg_b     = row_grad(win_b);
  assign cg_b     = col_grad(win_b);
  assign sum_a    = 12'(rg_a) + 12'(cg_a);
  assign sum_b    = 12'(rg_b) + 12'(cg_b);
  assign s1_n     = s1_v_r ? (2'(s1_emit1_r) + 2'(s1_emit2_r)) : 2'd0;

  // Running min/max: first result, then the right-edge one.
  always_comb begin
    min_a = min_r;
    max_a = max_r;
    if (s1_emit1_r) begin
      if (sum_a < min_a) min_a = sum_a;
      if (sum_a > $signed({1'b0, max_a})) max_a = sum_a[10:0];
    end
    min_b = min_a;
    max_b = max_a;
    if (s1_emit2_r) begin
      if (sum_b < min_b) min_b = sum_b;
      if (sum_b > $signed({1'b0, max_b})) max_b = sum_b[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      win_r <= '0;
      min_r <= MIN_START;
      max_r <= '0;
    end else if (s1_v_r) begin
      win_r <= s1_emit2_r ? win_b : win_a;
      if (s1_emit2_r && s1_last_r) begin
        min_r <= MIN_START;
        max_r <= '0;
      end else begin
        min_r <= min_b;
        max_r <= max_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v1_r <= 1'b0;
      s2_v2_r <= 1'b0;
    end else begin
      s2_v1_r <= s1_v_r && s1_emit1_r;
      s2_v2_r <= s1_v_r && s1_emit2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_res1_r <= '{row_gradient: rg_a, column_gradient: cg_a, gradient_sum: sum_a,
                     direction_bin: 4'd0, frame_last: 1'b0,
                     frame_min: min_a, frame_max: max_a};
      s2_res2_r <= '{row_gradient: rg_b, column_gradient: cg_b, gradient_sum: sum_b,
                     direction_bin: 4'd0, frame_last: s1_last_r,
                     frame_min: min_b, frame_max: max_b};
    end
  end

  // Fill in the direction bins on the way into the queue.
  always_comb begin
    res1               = s2_res1_r;
    res1.direction_bin = dir_bin(s2_res1_r.row_gradient, s2_res1_r.column_gradient);
    res2               = s2_res2_r;
    res2.direction_bin = dir_bin(s2_res2_r.row_gradient, s2_res2_r.column_gradient);
  end

  assign s2_n = 2'(s2_v1_r) + 2'(s2_v2_r);
  assign pop  = out_res.valid && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + OUT_PTR_W'(s2_n);
      rp_r  <= rp_r + OUT_PTR_W'(pop);
      cnt_r <= cnt_r + OUT_CNT_W'(s2_n) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v1_r) begin
      q_r[wp_r] <= res1;
    end
    if (s2_v2_r) begin
      q_r[wp_r + OUT_PTR_W'(s2_v1_r)] <= res2;
    end
  end

  assign head                    = q_r[rp_r];
  assign out_res.valid           = cnt_r != '0;
  assign out_res.row_gradient    = head.row_gradient;
  assign out_res.column_gradient = head.column_gradient;
  assign out_res.gradient_sum    = head.gradient_sum;
  assign out_res.direction_bin   = head.direction_bin;
  assign out_res.frame_last      = head.frame_last;
  assign out_res.frame_min       = head.frame_min;
  assign out_res.frame_max       = head.frame_max;

  // queue never overflows given the ready rule
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("output queue overflow");

  // the line store read never hits the column being written back
  a_mem_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (take && s1_v_r) |-> (col_r != s1_addr_r))
    else $error("line store read/write collision");

  // reported minimum never exceeds reported maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.frame_min <= $signed({1'b0, out_res.frame_max})))
    else $error("frame_min above frame_max");

  // bins stay in 0..8
  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.direction_bin <= 4'd8))
    else $error("direction bin out of range");

  // a result at the window stage reaches the bin stage next cycle
  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_n != 2'd0) |=> (s2_n == $past(s1_n)))
    else $error("result lost between window and bin stages");

endmodule

// ===== sim/tb_prewitt_gradient_direction_bins.sv =====
// Testbench for the Prewitt gradient block: pixel frames scored beat by beat against a predictor.
module tb_prewitt_gradient_direction_bins;
  import pgdb_pkg::*;

  localparam int  STALL_LIMIT   = 4000;
  localparam int  SETTLE_CYCLES = 12;
  localparam int  RANDOM_BEATS  = 440;
  localparam int  WIDE_BEATS    = 120;
  localparam real PI_VAL        = 3.14159265358979323846;
  localparam int  SUM_CEILING   = 1530;

  // indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       filler;
    bit         drain_first;  // hold this beat until every result is out
  } pix_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pgdb_pix_if pix_if ();
  pgdb_res_if res_if ();

  prewitt_gradient_direction_bins i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Gradient predictor: own copy of the frame geometry, the two line stores,
  // the 3x3 window, the raster position and the running min/max of the sum.
  // ---------------------------------------------------------------------------
  int unsigned grad_width;
  int unsigned grad_height;
  int unsigned col_pos;
  int unsigned row_pos;
  int          sum_floor;
  int          sum_peak;
  logic [7:0]  upper_row [MAX_WIDTH];
  logic [7:0]  lower_row [MAX_WIDTH];
  logic [7:0]  win [9];   // row * 3 + column, row 0 above, column 0 left
  res_t        expected_grads [$];

  // Traffic bookkeeping
  pix_beat_t pixel_backlog [$];
  int        beats_queued  = 0;
  int        beats_taken   = 0;
  int        payload_beats = 0;
  int        results_seen  = 0;
  int        frames_closed = 0;
  int        mismatches    = 0;
  int        stall_cycles  = 0;
  int        src_gap       = 0;
  int        snk_gap       = 0;
  bit        src_idle_en   = 1'b1;
  bit        snk_idle_en   = 1'b1;
  logic      pix_fire      = 1'b0;

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void restart_frame();
    foreach (win[k]) win[k] = 8'd0;
    col_pos   = 0;
    row_pos   = 0;
    sum_floor = SUM_CEILING;
    sum_peak  = 0;
  endfunction

  function automatic void shift_window(logic [7:0] up, logic [7:0] mid, logic [7:0] low);
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = low;
  endfunction

  // Fold the gradient angle into [0,180] degrees, then count the 20-degree
  // boundaries at or below it. Integer gradients never land on a boundary.
  function automatic logic [3:0] angle_bin(int rg, int cg);
    int   w;
    int   h;
    real  phi;
    logic [3:0] bin;
    w = rg;
    h = cg;
    if (h < 0) begin
      h = -h;
      w = -w;
    end
    if (h == 0) return (w < 0) ? 4'd8 : 4'd0;
    phi = $atan2(real'(h), real'(w)) * 180.0 / PI_VAL;
    bin = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (phi >= 20.0 * k) bin = bin + 4'd1;
    end
    return bin;
  endfunction

  function automatic void emit_center(bit last);
    int   rg;
    int   cg;
    int   sm;
    res_t r;
    rg = int'(win[6]) + int'(win[7]) + int'(win[8])
       - int'(win[0]) - int'(win[1]) - int'(win[2]);
    cg = int'(win[2]) + int'(win[5]) + int'(win[8])
       - int'(win[0]) - int'(win[3]) - int'(win[6]);
    sm = rg + cg;
    if (sm < sum_floor) sum_floor = sm;
    if (sm > sum_peak) sum_peak = sm;
    r.row_gradient    = 11'(rg);
    r.column_gradient = 11'(cg);
    r.gradient_sum    = 12'(sm);
    r.direction_bin   = angle_bin(rg, cg);
    r.frame_last      = last;
    r.frame_min       = 12'(sum_floor);
    r.frame_max       = 11'(sum_peak);
    expected_grads.push_back(r);
  endfunction

  // Advance the predictor by one accepted pixel beat.
  function automatic void take_pixel(pix_beat_t beat);
    bit          flushing;
    int unsigned c;
    int unsigned r;
    logic [7:0]  gray;
    logic [7:0]  up;
    logic [7:0]  mid;
    flushing = (row_pos >= grad_height);
    // drop filler inside the frame; in the flush row every beat counts
    if (!flushing && beat.filler) return;
    c    = col_pos;
    r    = row_pos;
    up   = 8'd0;
    mid  = 8'd0;
    gray = flushing ? 8'd0 : 8'((int'(beat.blue) + int'(beat.green) + int'(beat.red)) / 3);
    if (c == 0) foreach (win[k]) win[k] = 8'd0;
    if (r != 0) begin
      up  = upper_row[c];
      mid = lower_row[c];
    end
    upper_row[c] = mid;
    lower_row[c] = gray;
    shift_window(up, mid, gray);
    if (r >= 1 && c >= 1) emit_center(1'b0);
    if (c + 1 >= grad_width) begin
      // last column: close the row with a zero-padded right edge
      if (r >= 1) begin
        shift_window(8'd0, 8'd0, 8'd0);
        emit_center(flushing);
      end
      col_pos = 0;
      if (flushing) restart_frame();
      else row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int unsigned v;
    case (idx)
      REG_FRAME_WIDTH: begin
        v = val[WIDTH_W-1:0];
        if (v < 2) v = 2;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        grad_width = v;
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        v = val[HEIGHT_W-1:0];
        if (v < 2) v = 2;
        if (v > HEIGHT_LIMIT) v = HEIGHT_LIMIT;
        grad_height = v;
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic string result_text(res_t v);
    return $sformatf("rg=%0d cg=%0d sum=%0d bin=%0d last=%0b min=%0d max=%0d",
                     v.row_gradient, v.column_gradient, v.gradient_sum,
                     v.direction_bin, v.frame_last, v.frame_min, v.frame_max);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             logic filler, bit drain);
    pix_beat_t beat;
    beat.blue        = b;
    beat.green       = g;
    beat.red         = r;
    beat.filler      = filler;
    beat.drain_first = drain;
    pixel_backlog.push_back(beat);
    beats_queued++;
  endtask

  // Bias toward flat black/white and saturated channels for strong edges.
  task automatic queue_random_pixel(bit drain);
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g = b;
        r = b;
      end
      1: begin
        b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        b = 8'($urandom);
        g = 8'($urandom);
        r = 8'($urandom);
      end
    endcase
    queue_pixel(b, g, r, 1'b0, drain);
  endtask

  // Queue one frame of random pixels with stray filler, then the flush row.
  // A cut frame stops early and leaves the block mid-frame.
  task automatic send_frame(int w, int h, int cut_at);
    for (int i = 0; i < w * h && (cut_at < 0 || i < cut_at); i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0);
      queue_random_pixel($urandom_range(0, 39) == 0);
      payload_beats++;
    end
    if (cut_at < 0) begin
      for (int i = 0; i < w; i++) begin
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
        payload_beats++;
      end
    end
  endtask

  // Wait until every queued beat is taken and every result is out, then let
  // the pipeline empty of beats that produce nothing.
  task automatic wait_idle();
    while (beats_taken != beats_queued || expected_grads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: present the next backlog beat at the falling edge once the
  // current one has been taken; idle with junk payload during gaps.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_pixels
    pix_beat_t beat;
    bit        hold;
    if (rst_n && (!pix_if.valid || pix_fire)) begin
      hold = (pixel_backlog.size() == 0) || (src_gap != 0) ||
             (pixel_backlog[0].drain_first && expected_grads.size() != 0);
      if (hold) begin
        if (src_gap != 0) src_gap--;
        beat.blue   = 8'($urandom);
        beat.green  = 8'($urandom);
        beat.red    = 8'($urandom);
        beat.filler = 1'($urandom);
        pix_if.valid <= 1'b0;
      end else begin
        beat = pixel_backlog.pop_front();
        pix_if.valid <= 1'b1;
        src_gap = src_idle_en ? gap_len() : 0;
      end
      pix_if.blue      <= beat.blue;
      pix_if.green     <= beat.green;
      pix_if.red       <= beat.red;
      pix_if.is_filler <= beat.filler;
    end
  end

  // Result-side backpressure: drop ready for random stretches.
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (snk_gap != 0) begin
        snk_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (snk_idle_en && $urandom_range(0, 5) == 0) snk_gap = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: score result beats against the oldest expectation, then advance
  // the predictor with register writes and accepted pixel beats.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    res_t      seen;
    res_t      want;
    pix_beat_t beat_in;
    pix_fire <= rst_n && pix_if.valid && pix_if.ready;
    if (rst_n) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;

      if (res_if.valid && res_if.ready) begin
        seen = {res_if.row_gradient, res_if.column_gradient, res_if.gradient_sum,
                res_if.direction_bin, res_if.frame_last, res_if.frame_min,
                res_if.frame_max};
        results_seen++;
        if (seen.frame_last) frames_closed++;
        if (expected_grads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: %s",
                     results_seen, result_text(seen));
        end else begin
          want = expected_grads.pop_front();
          if (seen.row_gradient !== want.row_gradient ||
              seen.column_gradient !== want.column_gradient ||
              seen.gradient_sum !== want.gradient_sum ||
              seen.direction_bin !== want.direction_bin ||
              seen.frame_last !== want.frame_last ||
              seen.frame_min !== want.frame_min ||
              seen.frame_max !== want.frame_max) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch, got      %s", results_seen, result_text(seen));
              $display("result %0d mismatch, expected %s", results_seen, result_text(want));
            end
          end
        end
      end

      if (cfg_we) apply_reg(cfg_index, cfg_wdata);

      if (pix_if.valid && pix_if.ready) begin
        beat_in.blue        = pix_if.blue;
        beat_in.green       = pix_if.green;
        beat_in.red         = pix_if.red;
        beat_in.filler      = pix_if.is_filler;
        beat_in.drain_first = 1'b0;
        take_pixel(beat_in);
        beats_taken++;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("no beat moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int cur_w;
    int cur_h;
    int cut_at;
    int base_beats;
    bit restart_due;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_FRAME_WIDTH;
    cfg_wdata        = '0;
    pix_if.valid     = 1'b0;
    pix_if.blue      = 8'd0;
    pix_if.green     = 8'd0;
    pix_if.red       = 8'd0;
    pix_if.is_filler = 1'b0;
    res_if.ready     = 1'b0;

    grad_width  = WIDTH_RESET;
    grad_height = HEIGHT_RESET;
    restart_frame();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: 3x3 frame, bright top row over a dark bottom row, so the
    // center sees the full negative row gradient with a flat column
    // (horizontal negative, bin 8). A filler beat sits inside the frame and
    // the flush row mixes filler flags over bright junk data.
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    repeat (3) queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    queue_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
    queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0);
    repeat (2) queue_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
    repeat (3) queue_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);

    // Second frame back to back: every pixel grays to 85 through different
    // channel mixes, so the center has zero gradient (bin 0). Hold the third
    // row until the pipeline has drained.
    queue_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    queue_pixel(8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);
    queue_pixel(8'd85, 8'd85, 8'd85, 1'b0, 1'b0);
    queue_pixel(8'd1, 8'd0, 8'd254, 1'b0, 1'b0);
    queue_pixel(8'd86, 8'd86, 8'd85, 1'b0, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b1);
    queue_pixel(8'd100, 8'd100, 8'd55, 1'b0, 1'b0);
    queue_pixel(8'd170, 8'd85, 8'd0, 1'b0, 1'b0);
    repeat (3) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0);

    // Register extremes: zero and one clamp to the minimum frame, spare
    // indexes leave the geometry alone, all-ones clamp to the maximum.
    write_reg(REG_FRAME_WIDTH, 13'h0000);
    write_reg(REG_FRAME_HEIGHT, 13'h0001);
    send_frame(2, 2, -1);
    write_reg(REG_SPARE_A, 13'h1FFF);
    write_reg(REG_SPARE_B, 13'h0ABC);
    send_frame(2, 2, -1);
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    // part of the first row at the widest setting, then abandon the frame
    send_frame(MAX_WIDTH, HEIGHT_LIMIT, WIDE_BEATS);

    // Random frames: mostly small geometry, some cut short and restarted by
    // a register write, some reusing the previous geometry back to back.
    restart_due = 1'b1;
    cur_w       = 2;
    cur_h       = 2;
    base_beats  = payload_beats;
    while (payload_beats - base_beats < RANDOM_BEATS) begin
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 13'($urandom));
      if (restart_due || $urandom_range(0, 3) == 0) begin
        cur_w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
        cur_h = $urandom_range(2, 6);
        write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'(cur_w)});
        write_reg(REG_FRAME_HEIGHT, 13'(cur_h));
      end
      cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cur_w * cur_h - 1) : -1;
      send_frame(cur_w, cur_h, cut_at);
      restart_due = (cut_at >= 0);
    end

    wait_idle();
    $display("Covered %0d pixel beats, %0d results scored, %0d frames closed, %0d mismatches;",
             beats_taken, results_seen, frames_closed, mismatches);
    $display("geometry from 2x2 to a partial row at full width, cut frames, filler, stalls.");
    if (mismatches == 0 && expected_grads.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
